/* src/bws_pkg.sv */
package bws_pkg;

  // Configuration register set, as written through the configuration port
  typedef struct packed {
    logic [15:0] drive_gain;
    logic [15:0] shape_blend;
    logic [15:0] overdrive_mix;
  } cfg_t;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_DRIVE_GAIN    = 2'd0,
    REG_SHAPE_BLEND   = 2'd1,
    REG_OVERDRIVE_MIX = 2'd2
  } reg_idx_t;

  localparam cfg_t CFG_RST = '{drive_gain: 16'd16384, shape_blend: 16'd0, overdrive_mix: 16'd0};

  // Q1.15 reference points for the shape and overrange mixes
  localparam int Q15_ONE   = 32768;
  localparam int Q15_HALF  = 16384;
  localparam int WARP_BASE = 98304;

  // Q30 Taylor coefficients of sin(pi/2 z)
  localparam longint SIN_C1 = 64'sd1686629713;
  localparam longint SIN_C3 = -64'sd693598668;
  localparam longint SIN_C5 = 64'sd85569306;
  localparam longint SIN_C7 = -64'sd5026995;
  localparam longint SIN_C9 = 64'sd172272;

  // Register stages from curve index to curve point
  localparam int PT_LAT = 9;

endpackage

/* src/bws_point.sv */
module bws_point
  import bws_pkg::*;
#(
  parameter int CURVE_POINTS = 512,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [$clog2(CURVE_POINTS)-1:0] idx,
  input  cfg_t                          cfg,
  output logic signed [SAMPLE_BITS:0]   pt
);

  localparam int SB      = SAMPLE_BITS;
  localparam int ONE     = 1 << (SB - 1);
  localparam int LAST_PT = CURVE_POINTS - 1;
  localparam int M_ODD   = LAST_PT % 2;
  localparam int M_HALF  = LAST_PT / 2;
  localparam int IDX_W   = $clog2(CURVE_POINTS);
  localparam int KW      = IDX_W + 2;
  localparam int TBL_N   = M_HALF + 1;
  localparam int HW      = $clog2(TBL_N);
  localparam int VW      = SB + 1;
  localparam int DW      = SB + 3;
  localparam int OW      = SB + 4;
  localparam int PW      = SB + 22;

  localparam logic signed [VW-1:0] ONE_V = VW'(ONE);
  localparam logic signed [DW-1:0] ONE_D = DW'(ONE);
  localparam logic signed [OW-1:0] ONE_O = OW'(ONE);
  localparam logic signed [OW-1:0] TWO_O = OW'(2 * ONE);
  localparam logic signed [PW-1:0] ONE_P = PW'(ONE);

  function automatic longint rsr_const(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  // Magnitudes of the linear and sine shapes at |2i-M| = 2h + (M odd)
  function automatic logic [2*SB-1:0] tbl_entry(input int h);
    longint a, b, lin, z, z2, p, s;
    a   = 2 * h + M_ODD;
    lin = (a * ONE + M_HALF) / LAST_PT;
    b   = ((LAST_PT - a) < a) ? (LAST_PT - a) : a;
    z   = (b * 2 * (longint'(1) << 30) + M_HALF) / LAST_PT;
    z2  = rsr_const(z * z, 30);
    p   = SIN_C9;
    p   = SIN_C7 + rsr_const(p * z2, 30);
    p   = SIN_C5 + rsr_const(p * z2, 30);
    p   = SIN_C3 + rsr_const(p * z2, 30);
    p   = SIN_C1 + rsr_const(p * z2, 30);
    s   = rsr_const(rsr_const(p * z, 30), 31 - SB);
    if (s > ONE) s = ONE;
    if (s < 0) s = 0;
    return {SB'(lin), SB'(s)};
  endfunction

  // Round to nearest, halves away from zero
  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int sh);
    logic signed [PW-1:0] bias;
    bias = $signed(PW'(1) << (sh - 1)) - $signed(PW'(v[PW-1]));
    return (v + bias) >>> sh;
  endfunction

  logic [2*SB-1:0] tbl [TBL_N];

  for (genvar g = 0; g < TBL_N; g++) begin : g_tbl
    localparam logic [2*SB-1:0] ENT = tbl_entry(g);
    assign tbl[g] = ENT;
  end

  // Stage A: fold the index onto the table
  logic signed [KW-1:0] k;
  logic [KW-1:0]        a_mag;
  logic [KW-1:0]        a_off;
  logic [HW-1:0]        h_a;
  logic                 neg_a;

  assign k     = $signed({1'b0, idx, 1'b0}) - $signed(KW'(LAST_PT));
  assign a_mag = k[KW-1] ? $unsigned(-k) : $unsigned(k);
  assign a_off = a_mag - KW'(M_ODD);

  // Stage B: table read
  logic [2*SB-1:0]       ent;
  logic signed [VW-1:0]  lin_m, sin_m;
  logic signed [VW-1:0]  lin_b, sin_b;
  logic                  rneg_b;

  assign ent   = tbl[h_a];
  assign lin_m = $signed({1'b0, ent[2*SB-1:SB]});
  assign sin_m = $signed({1'b0, ent[SB-1:0]});

  // Stage C: shape blend products
  logic [15:0]          sh;
  logic                 sh_hi;
  logic [16:0]          w, wc;
  logic signed [VW-1:0] rect, fa, fb;
  logic signed [PW-1:0] prod1_c, prod2_c;

  assign sh    = (cfg.shape_blend > 16'(Q15_ONE)) ? 16'(Q15_ONE) : cfg.shape_blend;
  assign sh_hi = sh >= 16'(Q15_HALF);
  assign w     = sh_hi ? ({sh, 1'b0} - 17'(Q15_ONE)) : {sh, 1'b0};
  assign wc    = 17'(Q15_ONE) - w;
  assign rect  = rneg_b ? -ONE_V : ONE_V;
  assign fa    = sh_hi ? sin_b : lin_b;
  assign fb    = sh_hi ? rect : sin_b;

  // Stages D to F: blend rounding, drive product, drive rounding
  logic signed [VW-1:0] p_d;
  logic signed [PW-1:0] dprod_e;
  logic signed [DW-1:0] d_f;

  // Stage G: overrange operands
  logic [15:0]          od;
  logic                 fold, over_pos, over_neg;
  logic signed [OW-1:0] opa;
  logic signed [17:0]   opb;
  logic signed [OW-1:0] opa_g;
  logic signed [17:0]   opb_g;
  logic signed [DW-1:0] d_g;
  logic                 pos_g, neg_g, fold_g;

  assign od       = (cfg.overdrive_mix > 16'(Q15_ONE)) ? 16'(Q15_ONE) : cfg.overdrive_mix;
  assign fold     = od <= 16'(Q15_HALF);
  assign over_pos = d_f > ONE_D;
  assign over_neg = d_f < -ONE_D;
  assign opa      = fold ? (over_pos ? OW'(d_f) - ONE_O : OW'(d_f) + ONE_O)
                         : (over_pos ? TWO_O - OW'(d_f) : -TWO_O - OW'(d_f));
  assign opb      = fold ? $signed({2'b00, od}) : $signed(18'(WARP_BASE) - {od, 2'b00});

  // Stage H: overrange product
  logic signed [PW-1:0] oprod_h;
  logic signed [DW-1:0] d_h;
  logic                 pos_h, neg_h, fold_h;

  // Stage I: finish and clamp
  logic signed [PW-1:0] r14, r15, res, res_c;

  assign r14 = rnd(oprod_h, 14);
  assign r15 = rnd(oprod_h, 15);

  always_comb begin
    priority if (!(pos_h || neg_h)) begin
      res = PW'(d_h);
    end else if (fold_h) begin
      res = pos_h ? (ONE_P - r14) : (-ONE_P - r14);
    end else begin
      res = r15;
    end
    priority if (res > ONE_P) begin
      res_c = ONE_P;
    end else if (res < -ONE_P) begin
      res_c = -ONE_P;
    end else begin
      res_c = res;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_a     <= a_off[HW:1];
      neg_a   <= k[KW-1];
      lin_b   <= neg_a ? -lin_m : lin_m;
      sin_b   <= neg_a ? -sin_m : sin_m;
      rneg_b  <= neg_a;
      prod1_c <= PW'(fa) * PW'($signed({1'b0, wc}));
      prod2_c <= PW'(fb) * PW'($signed({1'b0, w}));
      p_d     <= VW'(rnd(prod1_c + prod2_c, 15));
      dprod_e <= PW'(p_d) * PW'($signed({1'b0, cfg.drive_gain}));
      d_f     <= DW'(rnd(dprod_e, 14));
      opa_g   <= opa;
      opb_g   <= opb;
      d_g     <= d_f;
      pos_g   <= over_pos;
      neg_g   <= over_neg;
      fold_g  <= fold;
      oprod_h <= PW'(opa_g) * PW'(opb_g);
      d_h     <= d_g;
      pos_h   <= pos_g;
      neg_h   <= neg_g;
      fold_h  <= fold_g;
      pt      <= VW'(res_c);
    end
  end

endmodule

/* src/blended_waveshaper.sv */
// Each item passes the input, position, curve-point and product registers to the output.
// Throughput: one item per cycle; the pipeline advances whenever the skid register is empty.
// A stalled output first fills the skid register, then holds the whole pipeline in place.
// Reset (rst, synchronous, active high) clears all valid bits and loads the register
// defaults: drive_gain 1.0, shape_blend linear, overdrive_mix limit.
module blended_waveshaper
  import bws_pkg::*;
#(
  parameter int CURVE_POINTS = 512,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input stream
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample_in
  input  logic                                  s_tlast,   // block_last
  // output stream
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,   // sample_out
  output logic                                  m_tlast,   // block_last_out
  // configuration writes
  input  logic                                  cfg_wr_en,
  input  logic [1:0]                            cfg_index,
  input  logic [15:0]                           cfg_data
);

  localparam int SB      = SAMPLE_BITS;
  localparam int TDW     = ((SB + 7) / 8) * 8;
  localparam int ONE     = 1 << (SB - 1);
  localparam int FULL    = 1 << SB;
  localparam int LAST_PT = CURVE_POINTS - 1;
  localparam int IDX_W   = $clog2(CURVE_POINTS);
  localparam int POSW    = SB + IDX_W;
  localparam int VW      = SB + 1;
  localparam int IW      = 2 * SB + 4;
  localparam int NST     = PT_LAT + 3;
  // Weight limits: below 0.001 take the low point, above 0.999 the high point
  localparam int     F_LO = (FULL - 1) / 1000;
  localparam longint F_HI = (64'sd999 * FULL) / 1000;

  localparam logic signed [IW-1:0] MAX_OUT = IW'(ONE - 1);

  function automatic logic signed [IW-1:0] rnd(input logic signed [IW-1:0] v, input int sh);
    logic signed [IW-1:0] bias;
    bias = $signed(IW'(1) << (sh - 1)) - $signed(IW'(v[IW-1]));
    return (v + bias) >>> sh;
  endfunction

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DRIVE_GAIN:    cfg.drive_gain    <= cfg_data;
        REG_SHAPE_BLEND:   cfg.shape_blend   <= cfg_data;
        REG_OVERDRIVE_MIX: cfg.overdrive_mix <= cfg_data;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Flow control. The whole pipeline moves as one on en; en only drops
  // once the skid register holds an item, so s_tready is a register
  // output and never sees m_tready combinationally.
  // ------------------------------------------------------------------
  logic           en;
  logic           acc;
  logic [NST-1:0] vld;

  logic           out_valid, skid_valid;
  logic [SB-1:0]  out_sample, skid_sample;
  logic           out_last, skid_last;

  assign en       = !skid_valid;
  assign s_tready = en;
  assign acc      = s_tvalid && en;

  // valid bits travel alongside the data, one per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], acc};
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: input register
  // Stage 2: curve position pos = (x + 1) / 2 * (CURVE_POINTS - 1), split
  //          into point index and interpolation weight
  // ------------------------------------------------------------------
  logic [SB-1:0]    x1;
  logic             last1;
  logic [SB-1:0]    u;
  logic [POSW-1:0]  pos;

  logic [IDX_W-1:0] idx2, idx2_hi;
  logic [SB-1:0]    f2;
  logic             zero2, last2;

  // x + ONE for a two's complement sample is the sample with its sign bit flipped
  assign u       = {~x1[SB-1], x1[SB-2:0]};
  assign pos     = POSW'(u) * POSW'(LAST_PT);
  assign idx2_hi = idx2 + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= s_tdata[SB-1:0];
      last1 <= s_tlast;
      idx2  <= pos[POSW-1:SB];
      f2    <= pos[SB-1:0];
      zero2 <= x1 == '0;
      last2 <= last1;
    end
  end

  // ------------------------------------------------------------------
  // Curve points at the two neighbouring indices. The position never
  // reaches the last index, so idx + 1 is always a valid point.
  // ------------------------------------------------------------------
  logic signed [VW-1:0] lo_pt, hi_pt;

  bws_point #(
    .CURVE_POINTS (CURVE_POINTS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_pt_lo (
    .clk (clk),
    .en  (en),
    .idx (idx2),
    .cfg (cfg),
    .pt  (lo_pt)
  );

  bws_point #(
    .CURVE_POINTS (CURVE_POINTS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_pt_hi (
    .clk (clk),
    .en  (en),
    .idx (idx2_hi),
    .cfg (cfg),
    .pt  (hi_pt)
  );

  // Side information delayed to line up with the curve points
  logic [SB-1:0] f_d    [PT_LAT];
  logic [SB:0]   wlo_d  [PT_LAT];
  logic          zero_d [PT_LAT];
  logic          sello_d[PT_LAT];
  logic          selhi_d[PT_LAT];
  logic          last_d [PT_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      f_d[0]     <= f2;
      wlo_d[0]   <= (SB+1)'(FULL) - {1'b0, f2};
      zero_d[0]  <= zero2;
      sello_d[0] <= f2 <= SB'(F_LO);
      selhi_d[0] <= f2 > SB'(F_HI);
      last_d[0]  <= last2;
      for (int j = 1; j < PT_LAT; j++) begin
        f_d[j]     <= f_d[j-1];
        wlo_d[j]   <= wlo_d[j-1];
        zero_d[j]  <= zero_d[j-1];
        sello_d[j] <= sello_d[j-1];
        selhi_d[j] <= selhi_d[j-1];
        last_d[j]  <= last_d[j-1];
      end
    end
  end

  // ------------------------------------------------------------------
  // Interpolation products, then rounding, selection and saturation
  // ------------------------------------------------------------------
  logic signed [IW-1:0] plo, phi;
  logic signed [VW-1:0] lo12, hi12;
  logic                 zero12, sello12, selhi12, last12;

  always_ff @(posedge clk) begin
    if (en) begin
      plo     <= IW'(lo_pt) * IW'($signed({1'b0, wlo_d[PT_LAT-1]}));
      phi     <= IW'(hi_pt) * IW'($signed({1'b0, f_d[PT_LAT-1]}));
      lo12    <= lo_pt;
      hi12    <= hi_pt;
      zero12  <= zero_d[PT_LAT-1];
      sello12 <= sello_d[PT_LAT-1];
      selhi12 <= selhi_d[PT_LAT-1];
      last12  <= last_d[PT_LAT-1];
    end
  end

  logic signed [IW-1:0] y_full, y_sat;
  logic [SB-1:0]        y;
  logic                 inc_valid;

  always_comb begin
    priority if (zero12) begin
      y_full = '0;
    end else if (sello12) begin
      y_full = IW'(lo12);
    end else if (selhi12) begin
      y_full = IW'(hi12);
    end else begin
      y_full = rnd(plo + phi, SB);
    end
    // +1.0 does not fit the output format: saturate just below it
    y_sat = (y_full > MAX_OUT) ? MAX_OUT : y_full;
  end

  assign y         = y_sat[SB-1:0];
  assign inc_valid = vld[NST-1] && en;

  // ------------------------------------------------------------------
  // Output register with skid: an item leaving the pipeline while the
  // output waits is parked in the skid register, which then stalls the
  // pipeline until the output drains.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid  <= skid_valid || inc_valid;
      skid_valid <= 1'b0;
    end else if (inc_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_sample <= skid_valid ? skid_sample : y;
      out_last   <= skid_valid ? skid_last : last12;
    end else if (inc_valid) begin
      skid_sample <= y;
      skid_last   <= last12;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDW'(out_sample);
  assign m_tlast  = out_last;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an item while the output is empty");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_valid && !m_tready) |=> (skid_valid && $stable(skid_sample)))
    else $error("parked item changed or vanished while the output was stalled");

  a_exit_parked: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && en && out_valid && !m_tready) |=> skid_valid)
    else $error("item leaving the pipeline was lost behind a stalled output");

endmodule
